// ===== rtl/core/gbd_pkg.sv =====
// Shared types, constants and helper functions of the grid BFS distance map.
`timescale 1ns / 1ps
`default_nettype none

package gbd_pkg;

  localparam int ROWS   = 16;
  localparam int COLS   = 16;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 4;
  localparam int NCELLS = ROWS * COLS;
  localparam int CELL_W = $clog2(NCELLS);
  localparam int PTR_W  = CELL_W + 1;
  localparam int DIST_W = 9;
  localparam int OUT_DIST_W = 10;
  localparam int QE_W   = ROW_W + COL_W + DIST_W;

  localparam logic [ROW_W:0]    ROWS_L   = (ROW_W + 1)'(ROWS);
  localparam logic [COL_W:0]    COLS_L   = (COL_W + 1)'(COLS);
  localparam logic [PTR_W-1:0]  NCELLS_L = PTR_W'(NCELLS);

  localparam logic [DIST_W-1:0] DIST_START = DIST_W'(1);
  localparam logic [DIST_W-1:0] DIST_MAX   = '1;
  localparam logic signed [OUT_DIST_W-1:0] DIST_UNREACHED = '1;

  typedef enum logic [1:0] {
    ACT_SET    = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    DIR_S = 2'd0,
    DIR_N = 2'd1,
    DIR_E = 2'd2,
    DIR_W = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_READ_WAIT,
    S_POP,
    S_LOAD,
    S_NB_S,
    S_NB_N,
    S_NB_E,
    S_NB_W,
    S_NB_END
  } state_t;

  // One frontier queue entry: the cell and the distance it gets.
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DIST_W-1:0] dist_val;
  } q_entry_t;

  typedef struct packed {
    logic    clear_obst;
    logic    capture;
    logic    write_obst;
    logic    search_init;
    logic    pop;
    logic    load;
    logic    try_nb;
    dir_t    dir;
    logic    respond;
    logic    respond_read;
  } ctrl_cmd_t;

  typedef struct packed {
    logic    clear_last;
    logic    bad;
    action_t action;
    logic    queue_empty;
  } dp_status_t;

  function automatic logic [CELL_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    return CELL_W'(row) * CELL_W'(COLS) + CELL_W'(col);
  endfunction

  function automatic logic cell_bad(input logic [ROW_W-1:0] row,
                                    input logic [COL_W-1:0] col);
    return ({1'b0, row} >= ROWS_L) || ({1'b0, col} >= COLS_L);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/grid_bfs_distance_map_top.sv =====
// Top level of the grid BFS distance map: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// The block holds an obstacle map of a 16 by 16 grid and a distance map built by a
// four-neighbor breadth-first flood. A transaction is offered on in_action,
// in_cell_row and in_cell_col with start; it is taken at a rising edge where start
// is high and busy is low. Actions are set obstacle, clear obstacle, search from a
// cell and read a cell. Every transaction yields exactly one result on out_distance,
// out_blocked and out_bad_cell, shown for one cycle while out_valid is high; the
// receiver cannot stall it. Out-of-grid cells give bad_cell with no state change.
// From the accepting edge, set, clear and out-of-grid cells respond from the
// dispatch step, and a read passes through a read-wait step first. During a search,
// for each reached cell the controller pops the frontier queue memory, loads the
// entry, reads the obstacle memory for each neighbor in turn, and then finishes the
// last neighbor check, since the obstacle memory read is registered. Busy stays high
// through that whole sequence, and the result register lets the next transaction
// start while a result is still shown. After reset busy stays high while the
// obstacle memory is cleared one cell per cycle; the distance-valid bits are cleared
// by reset, so every cell then reads free and unreached.

module grid_bfs_distance_map_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output      logic                                  busy,
  input  wire logic [1:0]                            in_action,
  input  wire logic [gbd_pkg::ROW_W-1:0]             in_cell_row,
  input  wire logic [gbd_pkg::COL_W-1:0]             in_cell_col,
  output      logic                                  out_valid,
  output      logic signed [gbd_pkg::OUT_DIST_W-1:0] out_distance,
  output      logic                                  out_blocked,
  output      logic                                  out_bad_cell
);

  gbd_pkg::ctrl_cmd_t  cmd;
  gbd_pkg::dp_status_t status;

  // The controller walks each transaction through its steps.
  gbd_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath owns all maps, the frontier queue and the result register.
  gbd_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_action    (in_action),
    .in_cell_row  (in_cell_row),
    .in_cell_col  (in_cell_col),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_distance (out_distance),
    .out_blocked  (out_blocked),
    .out_bad_cell (out_bad_cell)
  );

endmodule

`default_nettype wire

// ===== rtl/core/gbd_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module gbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/gbd_ctrl.sv =====
// Controller state machine that sequences commands, obstacle updates and the flood.
`timescale 1ns / 1ps
`default_nettype none

module gbd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire gbd_pkg::dp_status_t  status,
  output      gbd_pkg::ctrl_cmd_t   cmd,
  output      logic                 busy
);

  gbd_pkg::state_t state_r;
  gbd_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbd_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.dir   = gbd_pkg::DIR_S;
    busy      = (state_r != gbd_pkg::S_IDLE);
    unique case (state_r)
      gbd_pkg::S_CLEAR: begin
        // Clear the obstacle memory one cell per cycle after reset.
        cmd.clear_obst = 1'b1;
        if (status.clear_last) begin
          state_nxt = gbd_pkg::S_IDLE;
        end
      end
      gbd_pkg::S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = gbd_pkg::S_DISPATCH;
        end
      end
      gbd_pkg::S_DISPATCH: begin
        priority if (status.bad) begin
          cmd.respond = 1'b1;
          state_nxt   = gbd_pkg::S_IDLE;
        end else begin
          unique case (status.action)
            gbd_pkg::ACT_SET, gbd_pkg::ACT_CLEAR: begin
              cmd.write_obst = 1'b1;
              cmd.respond    = 1'b1;
              state_nxt      = gbd_pkg::S_IDLE;
            end
            gbd_pkg::ACT_SEARCH: begin
              cmd.search_init = 1'b1;
              state_nxt       = gbd_pkg::S_POP;
            end
            gbd_pkg::ACT_READ: begin
              state_nxt = gbd_pkg::S_READ_WAIT;
            end
            default: begin
              state_nxt = gbd_pkg::S_IDLE;
            end
          endcase
        end
      end
      gbd_pkg::S_READ_WAIT: begin
        cmd.respond_read = 1'b1;
        state_nxt        = gbd_pkg::S_IDLE;
      end
      gbd_pkg::S_POP: begin
        if (status.queue_empty) begin
          cmd.respond = 1'b1;
          state_nxt   = gbd_pkg::S_IDLE;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = gbd_pkg::S_LOAD;
        end
      end
      gbd_pkg::S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = gbd_pkg::S_NB_S;
      end
      gbd_pkg::S_NB_S: begin
        cmd.try_nb = 1'b1;
        cmd.dir    = gbd_pkg::DIR_S;
        state_nxt  = gbd_pkg::S_NB_N;
      end
      gbd_pkg::S_NB_N: begin
        cmd.try_nb = 1'b1;
        cmd.dir    = gbd_pkg::DIR_N;
        state_nxt  = gbd_pkg::S_NB_E;
      end
      gbd_pkg::S_NB_E: begin
        cmd.try_nb = 1'b1;
        cmd.dir    = gbd_pkg::DIR_E;
        state_nxt  = gbd_pkg::S_NB_W;
      end
      gbd_pkg::S_NB_W: begin
        cmd.try_nb = 1'b1;
        cmd.dir    = gbd_pkg::DIR_W;
        state_nxt  = gbd_pkg::S_NB_END;
      end
      gbd_pkg::S_NB_END: begin
        // The west neighbor is checked here, so the queue is settled before the pop.
        state_nxt = gbd_pkg::S_POP;
      end
      default: begin
        state_nxt = gbd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/gbd_datapath.sv =====
// Datapath: obstacle memory, frontier queue, distance memory with valid bits, results.
`timescale 1ns / 1ps
`default_nettype none

module gbd_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic [1:0]                            in_action,
  input  wire logic [gbd_pkg::ROW_W-1:0]             in_cell_row,
  input  wire logic [gbd_pkg::COL_W-1:0]             in_cell_col,
  input  wire gbd_pkg::ctrl_cmd_t                    cmd,
  output      gbd_pkg::dp_status_t                   status,
  output      logic                                  out_valid,
  output      logic signed [gbd_pkg::OUT_DIST_W-1:0] out_distance,
  output      logic                                  out_blocked,
  output      logic                                  out_bad_cell
);

  // Captured transaction.
  gbd_pkg::action_t                act_r;
  logic [gbd_pkg::ROW_W-1:0]       row_r;
  logic [gbd_pkg::COL_W-1:0]       col_r;
  logic [gbd_pkg::CELL_W-1:0]      cell_idx;
  logic                            bad;

  // Valid bits of the distance memory. A cell's bit is set when the flood first
  // reaches it, so the same bits mark the cells visited by the current search.
  logic [gbd_pkg::NCELLS-1:0]      dvalid_r;

  // Obstacle memory and its clearing pass after reset.
  logic [gbd_pkg::CELL_W-1:0]      clr_idx_r;
  logic                            obst_we;
  logic [gbd_pkg::CELL_W-1:0]      obst_waddr;
  logic                            obst_wdata;
  logic [gbd_pkg::CELL_W-1:0]      obst_raddr;
  logic                            obst_rdata;

  // Frontier queue pointers and the cell being expanded.
  logic [gbd_pkg::PTR_W-1:0]       head_r;
  logic [gbd_pkg::PTR_W-1:0]       tail_r;
  gbd_pkg::q_entry_t               cur_r;

  logic                            q_we;
  logic [gbd_pkg::CELL_W-1:0]      q_waddr;
  gbd_pkg::q_entry_t               q_wdata;
  logic [gbd_pkg::QE_W-1:0]        q_rdata_raw;
  gbd_pkg::q_entry_t               q_rdata;

  logic                            d_we;
  logic [gbd_pkg::CELL_W-1:0]      d_waddr;
  logic [gbd_pkg::DIST_W-1:0]      d_wdata;
  logic [gbd_pkg::DIST_W-1:0]      d_rdata;

  logic [gbd_pkg::ROW_W-1:0]       nb_row;
  logic [gbd_pkg::COL_W-1:0]       nb_col;
  logic                            nb_in_grid;
  logic [gbd_pkg::CELL_W-1:0]      nb_idx;
  logic [gbd_pkg::DIST_W-1:0]      nb_dist;

  // Neighbor under check, registered in step with its obstacle memory read.
  logic                            chk_valid_r;
  logic                            chk_in_grid_r;
  logic [gbd_pkg::ROW_W-1:0]       chk_row_r;
  logic [gbd_pkg::COL_W-1:0]       chk_col_r;
  logic [gbd_pkg::CELL_W-1:0]      chk_idx;
  logic                            push;

  logic                            out_valid_r;
  logic signed [gbd_pkg::OUT_DIST_W-1:0] out_distance_r;
  logic                            out_blocked_r;
  logic                            out_bad_cell_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= gbd_pkg::action_t'(in_action);
      row_r <= in_cell_row;
      col_r <= in_cell_col;
    end
  end

  assign cell_idx = gbd_pkg::cell_index(row_r, col_r);
  assign bad      = gbd_pkg::cell_bad(row_r, col_r);

  assign status.clear_last  = &clr_idx_r;
  assign status.bad         = bad;
  assign status.action      = act_r;
  assign status.queue_empty = (head_r == tail_r);

  // Neighbor of the cell being expanded, one direction per cycle.
  always_comb begin
    nb_row     = cur_r.row;
    nb_col     = cur_r.col;
    nb_in_grid = 1'b0;
    unique case (cmd.dir)
      gbd_pkg::DIR_S: begin
        nb_row     = cur_r.row + 1'b1;
        nb_in_grid = (({1'b0, cur_r.row} + 1'b1) < gbd_pkg::ROWS_L);
      end
      gbd_pkg::DIR_N: begin
        nb_row     = cur_r.row - 1'b1;
        nb_in_grid = (cur_r.row != '0);
      end
      gbd_pkg::DIR_E: begin
        nb_col     = cur_r.col + 1'b1;
        nb_in_grid = (({1'b0, cur_r.col} + 1'b1) < gbd_pkg::COLS_L);
      end
      gbd_pkg::DIR_W: begin
        nb_col     = cur_r.col - 1'b1;
        nb_in_grid = (cur_r.col != '0);
      end
      default: begin
        nb_in_grid = 1'b0;
      end
    endcase
  end

  assign nb_idx  = gbd_pkg::cell_index(nb_row, nb_col);
  assign nb_dist = (cur_r.dist_val == gbd_pkg::DIST_MAX) ? cur_r.dist_val
                                                          : cur_r.dist_val + 1'b1;

  assign chk_idx = gbd_pkg::cell_index(chk_row_r, chk_col_r);
  assign push    = chk_valid_r && chk_in_grid_r && !dvalid_r[chk_idx] && !obst_rdata
                   && (tail_r < gbd_pkg::NCELLS_L);

  // Obstacle memory: cleared after reset, written by set and clear, read for the
  // addressed cell or for the neighbor being tried.
  assign obst_we    = cmd.clear_obst || cmd.write_obst;
  assign obst_waddr = cmd.clear_obst ? clr_idx_r : cell_idx;
  assign obst_wdata = !cmd.clear_obst && (act_r == gbd_pkg::ACT_SET);
  assign obst_raddr = cmd.try_nb ? nb_idx : cell_idx;

  gbd_ram #(
    .WIDTH (1),
    .DEPTH (gbd_pkg::NCELLS)
  ) u_obst_ram (
    .clk   (clk),
    .we    (obst_we),
    .waddr (obst_waddr),
    .wdata (obst_wdata),
    .raddr (obst_raddr),
    .rdata (obst_rdata)
  );

  // Queue write: the start cell on search setup, else a newly reached neighbor.
  assign q_we    = cmd.search_init || push;
  assign q_waddr = cmd.search_init ? '0 : tail_r[gbd_pkg::CELL_W-1:0];
  always_comb begin
    if (cmd.search_init) begin
      q_wdata.row      = row_r;
      q_wdata.col      = col_r;
      q_wdata.dist_val = gbd_pkg::DIST_START;
    end else begin
      q_wdata.row      = chk_row_r;
      q_wdata.col      = chk_col_r;
      q_wdata.dist_val = nb_dist;
    end
  end

  gbd_ram #(
    .WIDTH (gbd_pkg::QE_W),
    .DEPTH (gbd_pkg::NCELLS)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head_r[gbd_pkg::CELL_W-1:0]),
    .rdata (q_rdata_raw)
  );

  assign q_rdata = gbd_pkg::q_entry_t'(q_rdata_raw);

  // A cell's distance is written when it enters the queue.
  assign d_we    = cmd.search_init || push;
  assign d_waddr = cmd.search_init ? cell_idx : chk_idx;
  assign d_wdata = cmd.search_init ? gbd_pkg::DIST_START : nb_dist;

  gbd_ram #(
    .WIDTH (gbd_pkg::DIST_W),
    .DEPTH (gbd_pkg::NCELLS)
  ) u_dist_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (cell_idx),
    .rdata (d_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvalid_r    <= '0;
      clr_idx_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      chk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.respond || cmd.respond_read;
      chk_valid_r <= cmd.try_nb;
      if (cmd.clear_obst) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (cmd.search_init) begin
        dvalid_r <= {{(gbd_pkg::NCELLS - 1){1'b0}}, 1'b1} << cell_idx;
        head_r   <= '0;
        tail_r   <= gbd_pkg::PTR_W'(1);
      end else begin
        if (cmd.pop) begin
          head_r <= head_r + 1'b1;
        end
        if (push) begin
          dvalid_r[chk_idx] <= 1'b1;
          tail_r            <= tail_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r <= q_rdata;
    end
    if (cmd.try_nb) begin
      chk_in_grid_r <= nb_in_grid;
      chk_row_r     <= nb_row;
      chk_col_r     <= nb_col;
    end
    if (cmd.respond) begin
      out_distance_r <= '0;
      out_blocked_r  <= 1'b0;
      out_bad_cell_r <= bad;
    end else if (cmd.respond_read) begin
      out_distance_r <= dvalid_r[cell_idx] ? $signed({1'b0, d_rdata})
                                           : gbd_pkg::DIST_UNREACHED;
      out_blocked_r  <= obst_rdata;
      out_bad_cell_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_blocked  = out_blocked_r;
  assign out_bad_cell = out_bad_cell_r;

endmodule

`default_nettype wire

// ===== tb/grid_bfs_distance_map_top_test.sv =====
// Self-checking testbench for the grid BFS distance map top level.
`timescale 1ns / 1ps

// The bench keeps its own copy of the obstacle map and the distance map, and
// predicts the result of every transaction the block accepts. A driver clocked on
// the falling edge takes actions from a backlog that the stimulus block fills at
// time zero. A monitor on the rising edge records each accepted transaction, runs
// the prediction, and compares every result strobe against the oldest expected
// result, field by field. The stimulus opens with a short directed part: reads
// after reset, a search over an open grid, a search from a blocked start, a stale
// map read and an enclosed start. Then come random rounds: obstacle edits, walls
// with and without a gap, line clears, one search, and reads, mixed with loose
// random actions. The sender idles often, then very often, then never.

module grid_bfs_distance_map_top_test;
  import gbd_pkg::*;

  localparam int RANDOM_ACTIONS = 555;
  localparam int CYCLE_LIMIT    = 5000000;
  localparam int SETTLE_CYCLES  = 16;

  // One action as the driver offers it. When drain_first is set, the driver
  // holds this action back until every outstanding result has been checked.
  typedef struct {
    action_t    action;
    logic [3:0] row;
    logic [3:0] col;
    bit         drain_first;
  } grid_op_t;

  typedef struct packed {
    logic signed [OUT_DIST_W-1:0] distance;
    logic                         blocked;
    logic                         bad_cell;
  } grid_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [1:0]                   in_action = ACT_READ;
  logic [ROW_W-1:0]             in_cell_row = '0;
  logic [COL_W-1:0]             in_cell_col = '0;
  logic                         out_valid;
  logic signed [OUT_DIST_W-1:0] out_distance;
  logic                         out_blocked;
  logic                         out_bad_cell;

  // The bench's own view of the block's state.
  bit                           obstacle_bits [NCELLS];
  logic signed [OUT_DIST_W-1:0] distance_mem [NCELLS];

  grid_op_t     queued_actions [$];
  grid_result_t awaited_results [$];

  bit took_item = 1'b0;
  int total_items = 0;
  int items_taken = 0;
  int results_checked = 0;
  int search_count = 0;
  int read_count = 0;
  int edit_count = 0;
  int fail_count = 0;
  int sender_idle_pct;
  int cycle_count = 0;

  grid_bfs_distance_map_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_cell_row  (in_cell_row),
    .in_cell_col  (in_cell_col),
    .out_valid    (out_valid),
    .out_distance (out_distance),
    .out_blocked  (out_blocked),
    .out_bad_cell (out_bad_cell)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Breadth-first flood from the start cell. Neighbors are tried south, north,
  // east, west. The start cell is never tested for an obstacle.
  function automatic void flood_from(input int r0, input int c0);
    bit reached [NCELLS];
    int cell_q [$];
    int dist_q [$];
    int cur, d, nd, r, c, nr, nc, ni;
    int dr [4] = '{1, -1, 0, 0};
    int dc [4] = '{0, 0, 1, -1};
    for (int i = 0; i < NCELLS; i++) begin
      reached[i] = 1'b0;
      distance_mem[i] = DIST_UNREACHED;
    end
    reached[r0 * COLS + c0] = 1'b1;
    cell_q.push_back(r0 * COLS + c0);
    dist_q.push_back(1);
    while (cell_q.size() != 0) begin
      cur = cell_q.pop_front();
      d = dist_q.pop_front();
      nd = (d >= int'(DIST_MAX)) ? int'(DIST_MAX) : d + 1;
      distance_mem[cur] = OUT_DIST_W'(d);
      r = cur / COLS;
      c = cur % COLS;
      for (int k = 0; k < 4; k++) begin
        nr = r + dr[k];
        nc = c + dc[k];
        if (nr >= 0 && nr < ROWS && nc >= 0 && nc < COLS) begin
          ni = nr * COLS + nc;
          if (!reached[ni] && !obstacle_bits[ni]) begin
            reached[ni] = 1'b1;
            cell_q.push_back(ni);
            dist_q.push_back(nd);
          end
        end
      end
    end
  endfunction

  // Applies one accepted action to the bench state and returns its result.
  function automatic grid_result_t execute_action(input grid_op_t op);
    grid_result_t res;
    int idx;
    res = '0;
    if (op.row >= ROWS || op.col >= COLS) begin
      res.bad_cell = 1'b1;
      return res;
    end
    idx = op.row * COLS + op.col;
    case (op.action)
      ACT_SET:    obstacle_bits[idx] = 1'b1;
      ACT_CLEAR:  obstacle_bits[idx] = 1'b0;
      ACT_SEARCH: flood_from(op.row, op.col);
      default: begin
        res.distance = distance_mem[idx];
        res.blocked  = obstacle_bits[idx];
      end
    endcase
    return res;
  endfunction

  task automatic add_op(input action_t act, input int row, input int col,
                        input bit drain = 1'b0);
    grid_op_t op;
    op.action = act;
    op.row = row[3:0];
    op.col = col[3:0];
    op.drain_first = drain;
    queued_actions.push_back(op);
  endtask

  // The sender idles at 29 percent for the first third of the run, at 63 percent
  // for the second third, and never for the rest.
  always @* begin
    if (items_taken < total_items / 3)
      sender_idle_pct = 29;
    else if (items_taken < (2 * total_items) / 3)
      sender_idle_pct = 63;
    else
      sender_idle_pct = 0;
  end

  // Driver. An offered transaction stays on the ports until the monitor saw it
  // taken at the previous rising edge; only then is the next one considered.
  always @(negedge clk) begin : drive_proc
    grid_op_t next_op;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !took_item) begin
      // The block is still busy; keep offering the same transaction.
    end else if (queued_actions.size() == 0) begin
      start <= 1'b0;
    end else if (queued_actions[0].drain_first && awaited_results.size() != 0) begin
      start <= 1'b0;
    end else if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
    end else begin
      next_op = queued_actions.pop_front();
      in_action   <= next_op.action;
      in_cell_row <= next_op.row;
      in_cell_col <= next_op.col;
      start       <= 1'b1;
    end
  end

  // Monitor. Results are checked before the transaction taken at the same edge is
  // predicted; the block cannot answer in the same cycle anyway.
  always @(posedge clk) begin : watch_proc
    grid_op_t     seen_op;
    grid_result_t want;
    if (!rst_n) begin
      took_item <= 1'b0;
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $error("result with no transaction outstanding: distance %0d blocked %0b bad %0b",
                 out_distance, out_blocked, out_bad_cell);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (out_distance !== want.distance) begin
            $error("distance mismatch: expected %0d, got %0d", want.distance, out_distance);
            fail_count++;
          end
          if (out_blocked !== want.blocked) begin
            $error("blocked mismatch: expected %0b, got %0b", want.blocked, out_blocked);
            fail_count++;
          end
          if (out_bad_cell !== want.bad_cell) begin
            $error("bad_cell mismatch: expected %0b, got %0b", want.bad_cell, out_bad_cell);
            fail_count++;
          end
        end
      end
      took_item <= start && !busy;
      if (start && !busy) begin
        seen_op.action = action_t'(in_action);
        seen_op.row = in_cell_row;
        seen_op.col = in_cell_col;
        seen_op.drain_first = 1'b0;
        awaited_results.push_back(execute_action(seen_op));
        items_taken++;
        case (seen_op.action)
          ACT_SEARCH: search_count++;
          ACT_READ:   read_count++;
          default:    edit_count++;
        endcase
      end
    end
  end

  // Watchdog: even a run made only of searches ends far below this limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus_proc
    int roll, line_idx, gap, start_row, start_col, edit_row, edit_col;
    bit along_row;
    for (int i = 0; i < NCELLS; i++) begin
      obstacle_bits[i] = 1'b0;
      distance_mem[i] = DIST_UNREACHED;
    end

    // Directed part. After reset every cell reads free and unreached.
    add_op(ACT_READ, 0, 0);
    add_op(ACT_READ, 15, 15);
    // Open grid: the far corner is 30 hops away, so it reads 31. The read waits
    // until the search result has come back.
    add_op(ACT_SEARCH, 0, 0);
    add_op(ACT_READ, 15, 15, 1'b1);
    add_op(ACT_READ, 0, 0);
    // An obstacle set after a search leaves the old distance in place.
    add_op(ACT_SET, 15, 0);
    add_op(ACT_READ, 15, 0);
    // A search may start on an obstacle; the start still gets 1.
    add_op(ACT_SEARCH, 15, 0);
    add_op(ACT_READ, 15, 0);
    add_op(ACT_READ, 0, 15);
    // Wall off the top-left corner and search from the middle.
    add_op(ACT_SET, 0, 1);
    add_op(ACT_SET, 1, 0);
    add_op(ACT_SEARCH, 7, 8);
    add_op(ACT_READ, 0, 0);
    add_op(ACT_READ, 0, 1);
    // A search from inside the enclosure reaches only its start.
    add_op(ACT_SEARCH, 0, 0);
    add_op(ACT_READ, 0, 0);
    add_op(ACT_READ, 0, 2);
    add_op(ACT_CLEAR, 0, 1);
    add_op(ACT_CLEAR, 1, 0);
    add_op(ACT_CLEAR, 15, 0);
    add_op(ACT_READ, 0, 1);
    add_op(ACT_READ, 15, 0);

    // Random part. Most rounds build some obstacle layout, search once and read
    // the map back; the rest are loose single actions.
    while (queued_actions.size() < 23 + RANDOM_ACTIONS) begin
      roll = $urandom_range(99);
      if (roll < 20) begin
        add_op(action_t'($urandom_range(3)), $urandom_range(15), $urandom_range(15));
      end else begin
        along_row = $urandom_range(1);
        line_idx = $urandom_range(15);
        roll = $urandom_range(3);
        if (roll == 0) begin
          // A wall across the grid; a gap value of 16 means no gap at all.
          gap = $urandom_range(16);
          for (int k = 0; k < 16; k++) begin
            if (k != gap)
              add_op(ACT_SET, along_row ? line_idx : k, along_row ? k : line_idx);
          end
        end else if (roll == 1) begin
          for (int k = 0; k < 16; k++)
            add_op(ACT_CLEAR, along_row ? line_idx : k, along_row ? k : line_idx);
        end
        repeat ($urandom_range(8))
          add_op(($urandom_range(99) < 55) ? ACT_SET : ACT_CLEAR,
                 $urandom_range(15), $urandom_range(15));
        start_row = $urandom_range(15);
        start_col = $urandom_range(15);
        add_op(ACT_SEARCH, start_row, start_col, $urandom_range(5) == 0);
        add_op(ACT_READ, start_row, start_col);
        repeat ($urandom_range(3, 10))
          add_op(ACT_READ, $urandom_range(15), $urandom_range(15));
        if ($urandom_range(2) == 0) begin
          // Edit after the search, then read the same cell: the map is stale.
          edit_row = $urandom_range(15);
          edit_col = $urandom_range(15);
          add_op($urandom_range(1) ? ACT_SET : ACT_CLEAR, edit_row, edit_col);
          add_op(ACT_READ, edit_row, edit_col);
        end
      end
    end
    total_items = queued_actions.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do
      @(negedge clk);
    while (items_taken != total_items || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      fail_count++;
    end
    $display("Run covered %0d transactions: %0d searches, %0d reads, %0d obstacle edits.",
             items_taken, search_count, read_count, edit_count);
    $display("%0d results compared field by field in %0d cycles.",
             results_checked, cycle_count);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
